// File: src/ffa_pkg.sv
`default_nettype none
package ffa_pkg;
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_GROW  = 2'd2
    } cmd_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_OUT
    } state_t;

    // Operation applied to the whole row of cells at once.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEED,
        OP_WRITE,
        OP_REMOVE,
        OP_INSERT
    } op_t;
endpackage
`default_nettype wire

// File: src/ffa_cell.sv
`default_nettype none
module ffa_cell
    import ffa_pkg::*;
#(
    parameter int AW = 32,
    parameter int IW = 4
) (
    input  wire logic          clk,
    input  wire logic [IW-1:0] my_index,
    input  wire op_t           op,
    input  wire logic [IW-1:0] sel,
    input  wire logic [AW-1:0] wr_start,
    input  wire logic [AW-1:0] wr_length,
    input  wire logic [AW-1:0] right_start,
    input  wire logic [AW-1:0] right_length,
    input  wire logic [AW-1:0] left_start,
    input  wire logic [AW-1:0] left_length,
    output logic      [AW-1:0] start,
    output logic      [AW-1:0] length
);
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] length_reg, length_next;

    always_comb
    begin
        start_next  = start_reg;
        length_next = length_reg;
        unique case (op)
            OP_SEED:
            begin
                start_next  = '0;
                length_next = wr_length;
            end
            OP_WRITE:
            begin
                if (my_index == sel)
                begin
                    start_next  = wr_start;
                    length_next = wr_length;
                end
            end
            OP_REMOVE:
            begin
                if (my_index >= sel)
                begin
                    start_next  = right_start;
                    length_next = right_length;
                end
            end
            OP_INSERT:
            begin
                if (my_index == sel)
                begin
                    start_next  = wr_start;
                    length_next = wr_length;
                end
                else if (my_index > sel)
                begin
                    start_next  = left_start;
                    length_next = left_length;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        length_reg <= length_next;
    end

    assign start  = start_reg;
    assign length = length_reg;
endmodule
`default_nettype wire

// File: src/first_fit_free_list_allocator.sv
// First-fit free-list allocator.
// Input channel (in_valid/in_ready): command, offset, amount. One result per
// item on the output channel (out_valid/out_ready): status, position.
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the initial
// capacity and re-seeds the list; write only while idle.
// The free list sits in a row of BLOCKS cells. An item walks the row one
// entry per cycle to find its slot, then S_DECIDE, then S_APPLY in which the
// row shifts or writes at once (S_APPLY repeats for a merge on both sides),
// and the result state S_OUT.
// The time to out_valid is set by the entry scan; allocate stops at the
// first fit, grow reads only the last entry.
// Items are handled one at a time.
// Reset seeds one free extent of 65536 units starting at 0; in_ready stays
// low while the seeding is pending after reset or a configuration write.
// The result waits in the output register while the receiver stalls; the
// next item is taken once it has been delivered.
`default_nettype none
module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int BLOCKS    = 16,
    parameter int ADDR_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] offset,
    input  wire logic [31:0] amount,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      position,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = ADDR_BITS;
    localparam int IW = $clog2(BLOCKS);
    localparam int CW = $clog2(BLOCKS + 1);
    localparam logic [AW:0] AMAX = {1'b0, {AW{1'b1}}};

    logic [AW-1:0] cs [BLOCKS];
    logic [AW-1:0] cl [BLOCKS];

    state_t        state_reg, state_next;
    op_t           op;
    logic [IW-1:0] sel;
    logic [AW-1:0] wr_start, wr_length;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cap_reg, cap_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    cmd_reg;
    logic [AW-1:0] off_reg, amt_reg;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   pos_reg, pos_next;
    logic          hit_reg, hit_next;
    logic          seed_pending_reg;
    logic [AW-1:0] cfg_cap;
    logic [AW-1:0] seed_cap;

    assign cfg_cap = AW'(cfg_data);

    // Decide-stage operands (registered by the scan).
    logic [AW-1:0] p_start_reg, p_length_reg, n_start_reg, n_length_reg;
    logic [AW-1:0] p_start_next, p_length_next, n_start_next, n_length_next;
    // Decision result applied in S_APPLY.
    op_t           aop_reg, aop_next;
    logic [IW-1:0] asel_reg, asel_next;
    logic [AW-1:0] aws_reg, aws_next, awl_reg, awl_next;
    logic [AW-1:0] acap_reg, acap_next;
    logic [CW-1:0] acnt_reg, acnt_next;

    genvar g;
    generate
        for (g = 0; g < BLOCKS; g++)
        begin : g_cell
            ffa_cell #(.AW(AW), .IW(IW)) u_cell (
                .clk         (clk),
                .my_index    (IW'(g)),
                .op          (op),
                .sel         (sel),
                .wr_start    (wr_start),
                .wr_length   (wr_length),
                .right_start (cs[(g + 1) % BLOCKS]),
                .right_length(cl[(g + 1) % BLOCKS]),
                .left_start  (cs[(g + BLOCKS - 1) % BLOCKS]),
                .left_length (cl[(g + BLOCKS - 1) % BLOCKS]),
                .start       (cs[g]),
                .length      (cl[g])
            );
        end
    endgenerate

    function automatic logic [AW-1:0] sat(input logic [AW:0] s);
        sat = (s > AMAX) ? AMAX[AW-1:0] : s[AW-1:0];
    endfunction

    logic [IW-1:0] ip;
    logic [AW-1:0] cur_s, cur_l;
    logic [IW-1:0] last_i;
    assign ip     = idx_reg[IW-1:0];
    assign cur_s  = cs[ip];
    assign cur_l  = cl[ip];
    assign last_i = IW'(count_reg - CW'(1));

    logic          jp, jn;
    logic [AW:0]   pend, fend;
    logic [AW-1:0] tmp;

    assign in_ready  = (state_reg == S_IDLE) && !seed_pending_reg && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = status_reg;
    assign position  = pos_reg;
    assign seed_cap  = cap_reg;

    always_comb
    begin
        state_next    = state_reg;
        op            = OP_NONE;
        sel           = asel_reg;
        wr_start      = aws_reg;
        wr_length     = awl_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        hit_next      = hit_reg;
        p_start_next  = p_start_reg;
        p_length_next = p_length_reg;
        n_start_next  = n_start_reg;
        n_length_next = n_length_reg;
        aop_next      = aop_reg;
        asel_next     = asel_reg;
        aws_next      = aws_reg;
        awl_next      = awl_reg;
        acap_next     = acap_reg;
        acnt_next     = acnt_reg;
        jp            = 1'b0;
        jn            = 1'b0;
        pend          = '0;
        fend          = '0;
        tmp           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (seed_pending_reg)
                begin
                    op         = OP_SEED;
                    wr_length  = seed_cap;
                    count_next = (seed_cap != '0) ? CW'(1) : '0;
                end
                else if (in_valid && in_ready)
                begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (idx_reg >= count_reg)
                            state_next = S_DECIDE;
                        else if (cur_l >= amt_reg)
                        begin
                            hit_next      = 1'b1;
                            n_start_next  = cur_s;
                            n_length_next = cur_l;
                            state_next    = S_DECIDE;
                        end
                        else
                            idx_next = idx_reg + CW'(1);
                    end
                    CMD_FREE:
                    begin
                        if (idx_reg < count_reg && cur_s <= off_reg)
                        begin
                            p_start_next  = cur_s;
                            p_length_next = cur_l;
                            idx_next      = idx_reg + CW'(1);
                        end
                        else
                        begin
                            n_start_next  = cur_s;
                            n_length_next = cur_l;
                            state_next    = S_DECIDE;
                        end
                    end
                    CMD_GROW:
                    begin
                        p_start_next  = cs[last_i];
                        p_length_next = cl[last_i];
                        state_next    = S_DECIDE;
                    end
                    default:
                        state_next = S_DECIDE;
                endcase
            end
            S_DECIDE:
            begin
                aop_next  = OP_NONE;
                acap_next = cap_reg;
                acnt_next = count_reg;
                pos_next  = '0;
                state_next = S_APPLY;
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (!hit_reg)
                            status_next = ST_NOFIT;
                        else
                        begin
                            status_next = ST_DONE;
                            pos_next    = 32'(n_start_reg);
                            asel_next   = ip;
                            if (n_length_reg == amt_reg)
                            begin
                                aop_next  = OP_REMOVE;
                                acnt_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                aop_next = OP_WRITE;
                                aws_next = n_start_reg + amt_reg;
                                awl_next = n_length_reg - amt_reg;
                            end
                        end
                    end
                    CMD_FREE:
                    begin
                        pend = {1'b0, p_start_reg} + {1'b0, p_length_reg};
                        fend = {1'b0, off_reg} + {1'b0, amt_reg};
                        jp   = (idx_reg != '0) && (pend == {1'b0, off_reg});
                        jn   = (idx_reg < count_reg) && (fend == {1'b0, n_start_reg});
                        status_next = ST_DONE;
                        if (amt_reg == '0)
                            status_next = ST_IGNORED;
                        else if (jp && jn)
                        begin
                            tmp      = sat({1'b0, p_length_reg} + {1'b0, amt_reg});
                            aop_next = OP_WRITE;
                            asel_next = ip - IW'(1);
                            aws_next = p_start_reg;
                            awl_next = sat({1'b0, tmp} + {1'b0, n_length_reg});
                            // remove of the following entry done after write
                            acnt_next = count_reg - CW'(1);
                        end
                        else if (jp)
                        begin
                            aop_next  = OP_WRITE;
                            asel_next = ip - IW'(1);
                            aws_next  = p_start_reg;
                            awl_next  = sat({1'b0, p_length_reg} + {1'b0, amt_reg});
                        end
                        else if (jn)
                        begin
                            aop_next  = OP_WRITE;
                            asel_next = ip;
                            aws_next  = off_reg;
                            awl_next  = sat({1'b0, n_length_reg} + {1'b0, amt_reg});
                        end
                        else if (count_reg >= CW'(BLOCKS))
                            status_next = ST_FULL;
                        else
                        begin
                            aop_next  = OP_INSERT;
                            asel_next = ip;
                            aws_next  = off_reg;
                            awl_next  = amt_reg;
                            acnt_next = count_reg + CW'(1);
                        end
                    end
                    CMD_GROW:
                    begin
                        pend = {1'b0, p_start_reg} + {1'b0, p_length_reg};
                        status_next = ST_DONE;
                        if (amt_reg <= cap_reg)
                            status_next = ST_IGNORED;
                        else if (count_reg != '0 && pend == {1'b0, cap_reg})
                        begin
                            aop_next  = OP_WRITE;
                            asel_next = last_i;
                            aws_next  = p_start_reg;
                            awl_next  = sat({1'b0, p_length_reg}
                                            + {1'b0, amt_reg - cap_reg});
                            acap_next = amt_reg;
                        end
                        else if (count_reg >= CW'(BLOCKS))
                            status_next = ST_FULL;
                        else
                        begin
                            aop_next  = OP_INSERT;
                            asel_next = IW'(count_reg);
                            aws_next  = cap_reg;
                            awl_next  = amt_reg - cap_reg;
                            acap_next = amt_reg;
                            acnt_next = count_reg + CW'(1);
                        end
                    end
                    default:
                        status_next = ST_IGNORED;
                endcase
            end
            S_APPLY:
            begin
                op         = aop_reg;
                sel        = asel_reg;
                cap_next   = acap_reg;
                state_next = S_OUT;
                // A two-sided merge writes entry i-1, then the next cycle
                // removes entry i.
                if (cmd_reg == CMD_FREE && aop_reg == OP_WRITE && acnt_reg != count_reg)
                begin
                    aop_next   = OP_REMOVE;
                    asel_next  = asel_reg + IW'(1);
                    acnt_next  = count_reg;
                    count_next = acnt_reg;
                    state_next = S_APPLY;
                end
                else if (!(aop_reg == OP_REMOVE && cmd_reg == CMD_FREE))
                    count_next = acnt_reg;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            cap_reg          <= AW'(32'd65536);
            seed_pending_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg          <= cfg_cap;
                seed_pending_reg <= 1'b1;
                count_reg        <= count_next;
            end
            else
            begin
                cap_reg   <= cap_next;
                count_reg <= count_next;
                if (state_reg == S_IDLE)
                    seed_pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        pos_reg       <= pos_next;
        hit_reg       <= hit_next;
        p_start_reg   <= p_start_next;
        p_length_reg  <= p_length_next;
        n_start_reg   <= n_start_next;
        n_length_reg  <= n_length_next;
        aop_reg       <= aop_next;
        asel_reg      <= asel_next;
        aws_reg       <= aws_next;
        awl_reg       <= awl_next;
        acap_reg      <= acap_next;
        acnt_reg      <= acnt_next;
        if (in_valid && in_ready)
        begin
            cmd_reg <= command;
            off_reg <= AW'(offset);
            amt_reg <= AW'(amount);
        end
    end
endmodule
`default_nettype wire

// File: sim/first_fit_free_list_allocator_tb.sv
`timescale 1ns / 100ps
module first_fit_free_list_allocator_tb
    import ffa_pkg::*;
();

    localparam int BLOCKS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [32:0] AMAX = 33'h0_FFFF_FFFF;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] position;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [31:0] offset;
    logic [31:0] amount;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] position;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // free list shadow
    logic [31:0] ext_start [BLOCKS];
    logic [31:0] ext_len [BLOCKS];
    int          ext_count;
    logic [31:0] cur_capacity;

    alloc_result_t expected_results[$];
    int  error_count;
    int  idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    bit  timed_out;

    first_fit_free_list_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .offset(offset), .amount(amount),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .position(position),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > AMAX) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void reseed_list(logic [31:0] cap);
        for (int k = 0; k < BLOCKS; k++)
        begin
            ext_start[k] = '0;
            ext_len[k] = '0;
        end
        cur_capacity = cap;
        ext_len[0] = cap;
        ext_count = (cap != 0) ? 1 : 0;
    endfunction

    function automatic void drop_extent(int i);
        for (int k = i; k + 1 < ext_count; k++)
        begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        ext_count--;
    endfunction

    function automatic void add_extent(int i, logic [31:0] s, logic [31:0] l);
        for (int k = ext_count; k > i; k--)
        begin
            ext_start[k] = ext_start[k - 1];
            ext_len[k] = ext_len[k - 1];
        end
        ext_start[i] = s;
        ext_len[i] = l;
        ext_count++;
    endfunction

    function automatic alloc_result_t predict_result(logic [1:0] cmd, logic [31:0] off,
                                                     logic [31:0] amt);
        alloc_result_t r;
        int  i;
        bit  jp;
        bit  jn;
        r.status = ST_IGNORED;
        r.position = '0;
        if (cmd == CMD_ALLOC)
        begin
            r.status = ST_NOFIT;
            for (i = 0; i < ext_count; i++)
                if (ext_len[i] >= amt)
                begin
                    r.status = ST_DONE;
                    r.position = ext_start[i];
                    if (ext_len[i] == amt)
                        drop_extent(i);
                    else
                    begin
                        ext_len[i] = ext_len[i] - amt;
                        ext_start[i] = ext_start[i] + amt;
                    end
                    break;
                end
        end
        else if (cmd == CMD_FREE)
        begin
            if (amt != 0)
            begin
                i = 0;
                while (i < ext_count && ext_start[i] <= off)
                    i++;
                jp = i > 0 && ({1'b0, ext_start[i-1]} + {1'b0, ext_len[i-1]}) == {1'b0, off};
                jn = i < ext_count && ({1'b0, off} + {1'b0, amt}) == {1'b0, ext_start[i]};
                r.status = ST_DONE;
                if (jp && jn)
                begin
                    ext_len[i-1] = sat_sum(sat_sum(ext_len[i-1], amt), ext_len[i]);
                    drop_extent(i);
                end
                else if (jp)
                    ext_len[i-1] = sat_sum(ext_len[i-1], amt);
                else if (jn)
                begin
                    ext_start[i] = off;
                    ext_len[i] = sat_sum(ext_len[i], amt);
                end
                else if (ext_count >= BLOCKS)
                    r.status = ST_FULL;
                else
                    add_extent(i, off, amt);
            end
        end
        else if (cmd == CMD_GROW)
        begin
            if (amt > cur_capacity)
            begin
                r.status = ST_DONE;
                i = ext_count - 1;
                if (ext_count > 0 && ({1'b0, ext_start[i]} + {1'b0, ext_len[i]})
                        == {1'b0, cur_capacity})
                    ext_len[i] = sat_sum(ext_len[i], amt - cur_capacity);
                else if (ext_count >= BLOCKS)
                    r.status = ST_FULL;
                else
                    add_extent(ext_count, cur_capacity, amt - cur_capacity);
                if (r.status == ST_DONE)
                    cur_capacity = amt;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_item(logic [1:0] cmd, logic [31:0] off, logic [31:0] amt);
        alloc_result_t exp_r;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        offset <= off;
        amount <= amt;
        exp_r = predict_result(cmd, off, amt);
        expected_results = {expected_results, exp_r};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (BLOCKS + 10) @(posedge clk);
    endtask

    task automatic write_capacity(logic [31:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reseed_list(cap);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result status", 32'(status), 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (position !== want.position)
                    report_mismatch("position", position, want.position);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic random_op(int span);
        int r;
        logic [31:0] a;
        r = $urandom_range(99);
        a = $urandom_range(span);
        if (r < 40)
            send_item(CMD_ALLOC, '0, a);
        else if (r < 80)
            send_item(CMD_FREE, $urandom_range(cur_capacity > 0 ? 4 * span : span), a);
        else if (r < 90)
            send_item(CMD_GROW, '0, cur_capacity + $urandom_range(span) - span / 4);
        else if (r < 95)
            send_item(CMD_RESERVED, $urandom, $urandom);
        else
            send_item(cmd_t'($urandom_range(2)), $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_item(CMD_ALLOC, '0, 32'd0);
        send_item(CMD_ALLOC, '0, 32'd100);
        send_item(CMD_ALLOC, '0, 32'd100);
        send_item(CMD_ALLOC, '0, 32'hFFFF_FFFF);
        send_item(CMD_FREE, 32'd0, 32'd0);
        send_item(CMD_FREE, 32'd0, 32'd50);
        send_item(CMD_FREE, 32'd50, 32'd50);
        send_item(CMD_FREE, 32'd100, 32'd100);
        send_item(CMD_GROW, '0, 32'd100);
        send_item(CMD_GROW, '0, 32'd70000);
        send_item(CMD_ALLOC, '0, 32'd70000);
        send_item(CMD_GROW, '0, 32'd80000);
        send_item(CMD_FREE, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_item(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_GROW, '0, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_table_full();
        write_capacity(32'd0);
        send_item(CMD_ALLOC, '0, 32'd0);
        for (int k = 0; k < BLOCKS + 2; k++)
            send_item(CMD_FREE, 32'(k * 10), 32'd5);
        send_item(CMD_GROW, '0, 32'd1000);
        send_item(CMD_FREE, 32'd3, 32'd2);
        send_item(CMD_GROW, '0, 32'd1000);
    endtask

    task automatic test_random(int n, int span);
        for (int k = 0; k < n; k++)
            random_op(span);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(20, 64);
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0;
        offset = '0;
        amount = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_off = 1'b0;
        idle_pct = 38;
        error_count = 0;
        timed_out = 1'b0;
        reseed_list(32'd65536);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        write_capacity(32'd256);
        test_random(500, 64);
        idle_pct = 0;
        test_random(200, 64);
        idle_pct = 38;
        test_backpressure();
        write_capacity(32'hFFFF_FFFF);
        test_random(250, 32'h7FFF_FFFF);
        write_capacity(32'd1);
        test_random(300, 8);
        write_capacity(32'hAAAA_5555);
        test_random(250, 32'hFFFF);
        wait_drained();

        if (error_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
